@@ hw/rtl/uer_pkg.sv @@
// uer_pkg: word types, constants and the tenths lookup for the echo ranger
// no dependencies; imported by every module of the ranger
`default_nettype none

package uer_pkg;

   localparam int TIMEOUT_BITS = 20;
   localparam int CM_BITS      = 11;
   localparam int TENTHS_BITS  = 4;
   localparam int REM_BITS     = 6;
   localparam int PROD_BITS    = 10;

   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 20'd1000000;
   localparam logic [REM_BITS-1:0]     CM_DIVISOR    = 6'd58;
   localparam logic [REM_BITS-1:0]     REM_LAST      = 6'd57;
   localparam logic [3:0]              TENTHS_SCALE  = 4'd10;

   typedef struct packed {
      logic start_req;
      logic echo;
   } req_type;

   typedef struct packed {
      logic                   trigger;
      logic                   busy_res;
      logic                   done_res;
      logic                   timed_out;
      logic [CM_BITS-1:0]     distance_cm;
      logic [TENTHS_BITS-1:0] distance_tenths;
   } rsp_type;

   // sequencer commands to the distance counter
   typedef struct packed {
      logic load;
      logic step;
   } dist_ctl_type;

   // floor(rem * 10 / 58) for rem below 58
   function automatic logic [TENTHS_BITS-1:0] tenths_of(input logic [REM_BITS-1:0] rem);
      logic [PROD_BITS-1:0]   prod;
      logic [TENTHS_BITS-1:0] count;
      prod  = PROD_BITS'(rem) * PROD_BITS'(TENTHS_SCALE);
      count = '0;
      for (int k = 1; k < 10; k++) begin
         if (prod >= PROD_BITS'(k * 58)) begin
            count = count + TENTHS_BITS'(1);
         end
      end
      return count;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
// ultrasonic_echo_ranger: top level, input word register, result register, timeout csr
// depends on uer_pkg, uer_seq and uer_dist
`default_nettype none

// Ultrasonic ranging sequencer. Each req word is one microsecond tick with a start
// request and the sampled echo level; each tick word yields exactly one rsp word
// with the trigger level to drive, busy/done/timeout flags and, on a good done,
// the distance in whole centimetres and truncated tenths (echo width / 58). A
// start while idle drives the trigger low TRIG_LOW_TICKS ticks, then high
// TRIG_HIGH_TICKS ticks, then waits for echo to rise; timeout_ticks+1 low ticks
// without a rise end the measurement with timed_out. Echo width saturates at
// 2^WIDTH_BITS-1; distance is tracked incrementally, so no divider is needed.
// Throughput is one word per clock while rsp_stall is low; each word passes through
// the input word register and the result register, sequencer logic between them. A
// stalled result still lets one more req word be taken into the input register.
// csr writes to timeout_ticks take effect on the next tick.
module ultrasonic_echo_ranger
   import uer_pkg::*;
#(
   parameter int TRIG_LOW_TICKS  = 2,
   parameter int TRIG_HIGH_TICKS = 10,
   parameter int WIDTH_BITS      = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire req_type                 req_data,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      rsp_type                 rsp_data,
   input  wire logic                    csr_write_enable,
   input  wire logic [TIMEOUT_BITS-1:0] csr_write_data
);

   logic                    in_valid_ff, in_valid_in;
   req_type                 in_data_ff;
   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_data_ff;
   logic [TIMEOUT_BITS-1:0] timeout_ff;
   logic                    out_ready, fire, req_accept;
   rsp_type                 result;
   dist_ctl_type            dist_ctl;
   logic [CM_BITS-1:0]      distance_cm;
   logic [TENTHS_BITS-1:0]  distance_tenths;

   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && out_ready;
   assign req_stall  = in_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   uer_seq #(
      .TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
      .TRIG_HIGH_TICKS (TRIG_HIGH_TICKS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .item            (in_data_ff),
      .timeout_ticks   (timeout_ff),
      .distance_cm     (distance_cm),
      .distance_tenths (distance_tenths),
      .dist_ctl        (dist_ctl),
      .result          (result)
   );

   uer_dist #(
      .WIDTH_BITS (WIDTH_BITS)
   ) u_dist (
      .clock           (clock),
      .reset           (reset),
      .dist_ctl        (dist_ctl),
      .distance_cm     (distance_cm),
      .distance_tenths (distance_tenths)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/uer_dist.sv @@
// uer_dist: echo width counter kept together with its quotient and remainder by 58
// depends on uer_pkg
`default_nettype none

module uer_dist
   import uer_pkg::*;
#(
   parameter int WIDTH_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dist_ctl_type           dist_ctl,
   output      logic [CM_BITS-1:0]     distance_cm,
   output      logic [TENTHS_BITS-1:0] distance_tenths
);

   logic [WIDTH_BITS-1:0] width_ff, width_in;
   logic [CM_BITS-1:0]    cm_ff, cm_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;

   // quotient is kept modulo 2^CM_BITS, the width of the distance_cm output
   always_comb begin
      width_in = width_ff;
      cm_in    = cm_ff;
      rem_in   = rem_ff;
      if (dist_ctl.load) begin
         width_in = WIDTH_BITS'(1);
         cm_in    = '0;
         rem_in   = REM_BITS'(1);
      end else if (dist_ctl.step && (width_ff != {WIDTH_BITS{1'b1}})) begin
         width_in = width_ff + WIDTH_BITS'(1);
         if (rem_ff == REM_LAST) begin
            rem_in = '0;
            cm_in  = cm_ff + CM_BITS'(1);
         end else begin
            rem_in = rem_ff + REM_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= '0;
         cm_ff    <= '0;
         rem_ff   <= '0;
      end else begin
         width_ff <= width_in;
         cm_ff    <= cm_in;
         rem_ff   <= rem_in;
      end
   end

   assign distance_cm     = cm_ff;
   assign distance_tenths = tenths_of(rem_ff);

endmodule

`default_nettype wire

@@ hw/rtl/uer_seq.sv @@
// uer_seq: trigger / wait / measure sequencer, forms one result word per tick word
// depends on uer_pkg; drives uer_dist through a dist_ctl_type command
`default_nettype none

module uer_seq
   import uer_pkg::*;
#(
   parameter int TRIG_LOW_TICKS  = 2,
   parameter int TRIG_HIGH_TICKS = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire req_type                 item,
   input  wire logic [TIMEOUT_BITS-1:0] timeout_ticks,
   input  wire logic [CM_BITS-1:0]      distance_cm,
   input  wire logic [TENTHS_BITS-1:0]  distance_tenths,
   output      dist_ctl_type            dist_ctl,
   output      rsp_type                 result
);

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_TRIG_LOW  = 3'd1,
      PH_TRIG_HIGH = 3'd2,
      PH_WAIT_RISE = 3'd3,
      PH_MEASURE   = 3'd4
   } phase_type;

   phase_type                phase_ff, phase_in, phase_cur;
   logic [TIMEOUT_BITS-1:0]  tick_ff, tick_in, tick_cur, tick_inc;
   dist_ctl_type             ctl;

   always_comb begin
      phase_cur = phase_ff;
      tick_cur  = tick_ff;
      if ((phase_ff == PH_IDLE) && item.start_req) begin
         phase_cur = PH_TRIG_LOW;
         tick_cur  = '0;
      end
      tick_inc = tick_cur + TIMEOUT_BITS'(1);

      phase_in = phase_cur;
      tick_in  = tick_cur;
      ctl      = '0;
      result   = '0;

      unique case (phase_cur)
         PH_IDLE: begin
         end
         PH_TRIG_LOW: begin
            result.busy_res = 1'b1;
            tick_in         = tick_inc;
            if (tick_inc >= TIMEOUT_BITS'(TRIG_LOW_TICKS)) begin
               phase_in = PH_TRIG_HIGH;
               tick_in  = '0;
            end
         end
         PH_TRIG_HIGH: begin
            result.busy_res = 1'b1;
            result.trigger  = 1'b1;
            tick_in         = tick_inc;
            if (tick_inc >= TIMEOUT_BITS'(TRIG_HIGH_TICKS)) begin
               phase_in = PH_WAIT_RISE;
               tick_in  = '0;
            end
         end
         PH_WAIT_RISE: begin
            result.busy_res = 1'b1;
            if (item.echo) begin
               phase_in = PH_MEASURE;
               ctl.load = 1'b1;
            end else if (tick_cur == timeout_ticks) begin
               result.done_res  = 1'b1;
               result.timed_out = 1'b1;
               phase_in         = PH_IDLE;
               tick_in          = '0;
            end else begin
               tick_in = tick_inc;
            end
         end
         PH_MEASURE: begin
            result.busy_res = 1'b1;
            if (item.echo) begin
               ctl.step = 1'b1;
            end else begin
               result.done_res        = 1'b1;
               result.distance_cm     = distance_cm;
               result.distance_tenths = distance_tenths;
               phase_in               = PH_IDLE;
               tick_in                = '0;
            end
         end
         default: begin
            // stray phase code falls back to idle
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign dist_ctl = '{load: fire && ctl.load, step: fire && ctl.step};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

`default_nettype wire
